[design/wtsnd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wtsnd_pkg;

	// command codes of an input word
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_AUDIO = 2'd3
	} cmd_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CRD,
		S_LOAD,
		S_PREP,
		S_DIV,
		S_NIB,
		S_NIBD,
		S_MUL1,
		S_MUL2,
		S_WB,
		S_DONE
	} state_t;

	// address decode on bits 15..11
	localparam logic [4:0] REG_RAM    = 5'h09;	// 0x4800
	localparam logic [4:0] REG_CNT_LO = 5'h0A;	// 0x5000
	localparam logic [4:0] REG_CNT_HI = 5'h0B;	// 0x5800
	localparam logic [4:0] REG_SND    = 5'h1C;	// 0xE000
	localparam logic [4:0] REG_PTR    = 5'h1F;	// 0xF800

	localparam int          RAM_DEPTH    = 128;
	localparam logic [6:0]  CFG_ADDR     = 7'h7F;
	localparam logic [3:0]  TICKS_PER_CH = 4'd15;
	localparam logic [6:0]  GAIN_RESET   = 7'd34;
	localparam logic [15:0] CNT_MAX      = 16'hFFFF;
	// 52429 / 2^18 is 1/5 with error small enough for operands below 2^18
	localparam logic [15:0] RECIP5       = 16'd52429;
	localparam int          RECIP_SHIFT  = 18;
	localparam logic [3:0]  LOAD_LAST    = 4'd9;
	localparam logic [3:0]  DIV_LAST     = 4'd8;
	localparam logic [1:0]  WB_LAST      = 2'd2;

endpackage
`default_nettype wire

[design/wtsnd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module wtsnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[design/wavetable_sound_ram_and_irq_unit.sv]
// Path: CPU write, tick and register read go to DONE; wave RAM read adds CRD;
// sound-on audio adds LOAD to WB; DIV only on a channel slot's first tick.
// Throughput: one word at a time; the serial wave RAM accesses (ten loads, one
// sample fetch, three phase stores) and the bit-serial phase remainder set it.
// Reset: arst_n async low; RAM entries read as zero until written (per-entry
// valid flops), no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module wavetable_sound_ram_and_irq_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        cmd,
	input  wire logic [15:0]       address,
	input  wire logic [7:0]        write_data,
	input  wire logic [7:0]        open_bus,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             read_data,
	output logic                   irq_line,
	output logic                   sample_valid,
	output logic [2:0]             sample_channel,
	output logic signed [8:0]      sample_value,
	input  wire logic              cfg_we,
	input  wire logic [6:0]        cfg_wdata
);

	wtsnd_pkg::state_t state_q, state_d;

	// control state
	logic [6:0]   ptr_q;
	logic         inc_q;
	logic         sound_on_q;
	logic [3:0]   tick_q;
	logic [3:0]   act_q;
	logic [15:0]  irq_cnt_q;
	logic         irq_dly_q;
	logic         irq_pend_q;
	logic [6:0]   gain_q;
	logic [127:0] vld_q;
	logic [3:0]   ld_cnt_q;
	logic [3:0]   div_cnt_q;
	logic [1:0]   wb_cnt_q;
	logic         out_valid_q;

	// payload
	logic [6:0]         rd_addr_q;
	logic [2:0]         ch_q;
	logic [7:0]         chreg_q [8];
	logic [8:0]         dx_q;
	logic [7:0]         rem_q;
	logic [15:0]        lo16_q;
	logic [23:0]        phase_q;
	logic               nib_hi_q;
	logic signed [7:0]  raw_q;
	logic signed [15:0] prod_q;
	logic [9:0]         quo_q;
	logic               neg_q;
	logic [7:0]         res_rd_q;
	logic               res_sv_q;
	logic [2:0]         res_ch_q;
	logic signed [8:0]  res_val_q;
	logic [7:0]         read_data_q;
	logic               irq_q;
	logic               sv_q;
	logic [2:0]         ch_out_q;
	logic signed [8:0]  val_q;

	// RAM port
	logic       ram_we;
	logic [6:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic [6:0] ram_raddr;
	logic [7:0] ram_q;
	logic [7:0] rdata;

	wtsnd_ram #(
		.WIDTH(8),
		.DEPTH(wtsnd_pkg::RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_q)
	);

	// unwritten entries read as zero
	assign rdata = vld_q[rd_addr_q] ? ram_q : 8'h00;

	logic       acc;
	logic [4:0] region;
	logic       out_free;
	logic [6:0] ptr_next;
	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != wtsnd_pkg::S_IDLE);
	assign region   = address[15:11];
	assign out_free = !out_valid_q || !out_stall;
	assign ptr_next = ptr_q + {6'd0, inc_q};

	// channel select on the first register load
	logic [2:0] ch_now;
	logic [2:0] ld_off;
	logic [2:0] ld_wr;
	assign ch_now = act_q[3] ? (3'd7 - rdata[6:4]) : act_q[2:0];
	assign ld_off = ld_cnt_q[2:0] - 3'd1;
	// read data lags its address by the RAM's read register
	assign ld_wr  = ld_cnt_q[2:0] - 3'd2;

	// phase sum and wave length
	logic [23:0] p24;
	logic [17:0] f18;
	logic [24:0] sum25;
	logic [8:0]  span9;
	assign p24   = {chreg_q[5], chreg_q[3], chreg_q[1]};
	assign f18   = {chreg_q[4][1:0], chreg_q[2], chreg_q[0]};
	assign sum25 = {1'b0, p24} + {7'd0, f18};
	assign span9 = 9'd256 - {1'b0, chreg_q[4] & 8'hFC};

	// restoring remainder step, one bit per cycle
	logic [8:0] rem_sh;
	logic [8:0] rem_diff;
	logic [7:0] rem_nx;
	assign rem_sh   = {rem_q, dx_q[8]};
	assign rem_diff = rem_sh - span9;
	assign rem_nx   = (rem_sh >= span9) ? rem_diff[7:0] : rem_sh[7:0];

	// sample index and nibble
	logic [7:0]        idx8;
	logic [3:0]        nib;
	logic signed [4:0] nib_c;
	logic signed [9:0] raw_full;
	assign idx8     = phase_q[23:16] + chreg_q[6];
	assign nib      = nib_hi_q ? rdata[7:4] : rdata[3:0];
	assign nib_c    = $signed({1'b0, nib}) - 5'sd8;
	assign raw_full = nib_c * $signed({1'b0, chreg_q[7][3:0]});

	// gain and divide by 40 as (mag >> 3) / 5
	logic signed [15:0] prod_d;
	logic [15:0]        mag;
	logic [28:0]        quo_full;
	assign prod_d   = raw_q * $signed({1'b0, gain_q});
	assign mag      = prod_q[15] ? 16'(-prod_q) : 16'(prod_q);
	assign quo_full = mag[15:3] * wtsnd_pkg::RECIP5;

	// saturate to -256..255
	logic signed [8:0] sat_val;
	always_comb begin
		if (!neg_q) begin
			sat_val = (quo_q > 10'd255) ? 9'sd255 : $signed({1'b0, quo_q[7:0]});
		end else begin
			sat_val = (quo_q > 10'd256) ? $signed(9'h100) : $signed(9'd0 - quo_q[8:0]);
		end
	end

	// tick and channel advance
	logic [3:0] tick_inc;
	assign tick_inc = tick_q + 4'd1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtsnd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = write_data;
		ram_raddr = ptr_q;
		unique case (state_q)
			wtsnd_pkg::S_IDLE: begin
				if (acc) begin
					state_d = wtsnd_pkg::S_DONE;
					unique case (cmd)
						wtsnd_pkg::CMD_WRITE: begin
							ram_we = (region == wtsnd_pkg::REG_RAM);
						end
						wtsnd_pkg::CMD_READ: begin
							if (region == wtsnd_pkg::REG_RAM) begin
								state_d = wtsnd_pkg::S_CRD;
							end
						end
						wtsnd_pkg::CMD_TICK: begin
							state_d = wtsnd_pkg::S_DONE;
						end
						wtsnd_pkg::CMD_AUDIO: begin
							if (sound_on_q) begin
								state_d = wtsnd_pkg::S_LOAD;
							end
						end
						default: begin
							state_d = wtsnd_pkg::S_DONE;
						end
					endcase
				end
			end
			wtsnd_pkg::S_CRD: begin
				state_d = wtsnd_pkg::S_DONE;
			end
			wtsnd_pkg::S_LOAD: begin
				if (ld_cnt_q == 4'd0) begin
					ram_raddr = wtsnd_pkg::CFG_ADDR;
				end else if (ld_cnt_q == 4'd1) begin
					ram_raddr = {1'b1, ch_now, 3'd0};
				end else begin
					ram_raddr = {1'b1, ch_q, ld_off};
				end
				if (ld_cnt_q == wtsnd_pkg::LOAD_LAST) begin
					state_d = wtsnd_pkg::S_PREP;
				end
			end
			wtsnd_pkg::S_PREP: begin
				state_d = (tick_q == 4'd0) ? wtsnd_pkg::S_DIV : wtsnd_pkg::S_NIB;
			end
			wtsnd_pkg::S_DIV: begin
				if (div_cnt_q == wtsnd_pkg::DIV_LAST) begin
					state_d = wtsnd_pkg::S_NIB;
				end
			end
			wtsnd_pkg::S_NIB: begin
				ram_raddr = idx8[7:1];
				state_d   = wtsnd_pkg::S_NIBD;
			end
			wtsnd_pkg::S_NIBD: begin
				state_d = wtsnd_pkg::S_MUL1;
			end
			wtsnd_pkg::S_MUL1: begin
				state_d = wtsnd_pkg::S_MUL2;
			end
			wtsnd_pkg::S_MUL2: begin
				state_d = wtsnd_pkg::S_WB;
			end
			wtsnd_pkg::S_WB: begin
				ram_we = 1'b1;
				unique case (wb_cnt_q)
					2'd0: begin
						ram_waddr = {1'b1, ch_q, 3'd5};
						ram_wdata = phase_q[23:16];
					end
					2'd1: begin
						ram_waddr = {1'b1, ch_q, 3'd3};
						ram_wdata = phase_q[15:8];
					end
					default: begin
						ram_waddr = {1'b1, ch_q, 3'd1};
						ram_wdata = phase_q[7:0];
					end
				endcase
				if (wb_cnt_q == wtsnd_pkg::WB_LAST) begin
					state_d = wtsnd_pkg::S_DONE;
				end
			end
			wtsnd_pkg::S_DONE: begin
				if (out_free) begin
					state_d = wtsnd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = wtsnd_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			inc_q       <= 1'b1;
			sound_on_q  <= 1'b0;
			tick_q      <= '0;
			act_q       <= '0;
			irq_cnt_q   <= '0;
			irq_dly_q   <= 1'b0;
			irq_pend_q  <= 1'b0;
			gain_q      <= wtsnd_pkg::GAIN_RESET;
			vld_q       <= '0;
			ld_cnt_q    <= '0;
			div_cnt_q   <= '0;
			wb_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			// result register: load on leaving DONE, clear when taken
			if ((state_q == wtsnd_pkg::S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				wtsnd_pkg::S_IDLE: begin
					ld_cnt_q  <= '0;
					div_cnt_q <= '0;
					wb_cnt_q  <= '0;
					if (acc) begin
						unique case (cmd)
							wtsnd_pkg::CMD_WRITE: begin
								case (region)
									wtsnd_pkg::REG_RAM: begin
										ptr_q <= ptr_next;
									end
									wtsnd_pkg::REG_CNT_LO: begin
										irq_cnt_q[7:0] <= write_data;
										irq_pend_q     <= 1'b0;
									end
									wtsnd_pkg::REG_CNT_HI: begin
										irq_cnt_q[15:8] <= write_data;
										irq_pend_q      <= 1'b0;
									end
									wtsnd_pkg::REG_SND: begin
										sound_on_q <= !write_data[6];
									end
									wtsnd_pkg::REG_PTR: begin
										inc_q <= write_data[7];
										ptr_q <= write_data[6:0];
									end
									default: begin
									end
								endcase
							end
							wtsnd_pkg::CMD_READ: begin
								if (region == wtsnd_pkg::REG_RAM) begin
									ptr_q <= ptr_next;
								end
							end
							wtsnd_pkg::CMD_TICK: begin
								if (irq_dly_q) begin
									irq_pend_q <= 1'b1;
								end
								// delay flag is rearmed only when the count lands on max
								if (irq_cnt_q[15] && (irq_cnt_q != wtsnd_pkg::CNT_MAX)) begin
									irq_cnt_q <= irq_cnt_q + 16'd1;
									irq_dly_q <= (irq_cnt_q + 16'd1 == wtsnd_pkg::CNT_MAX);
								end else begin
									irq_dly_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				wtsnd_pkg::S_LOAD: begin
					ld_cnt_q <= ld_cnt_q + 4'd1;
				end
				wtsnd_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
				end
				wtsnd_pkg::S_WB: begin
					wb_cnt_q <= wb_cnt_q + 2'd1;
					if (wb_cnt_q == wtsnd_pkg::WB_LAST) begin
						if (tick_inc >= wtsnd_pkg::TICKS_PER_CH) begin
							tick_q <= '0;
							act_q  <= {1'b0, ch_q} + 4'd1;
						end else begin
							tick_q <= tick_inc;
							act_q  <= {1'b0, ch_q};
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_addr_q <= ram_raddr;
		unique case (state_q)
			wtsnd_pkg::S_IDLE: begin
				res_sv_q  <= 1'b0;
				res_ch_q  <= '0;
				res_val_q <= '0;
				if (acc && (cmd == wtsnd_pkg::CMD_READ)) begin
					case (region)
						wtsnd_pkg::REG_CNT_LO: res_rd_q <= irq_cnt_q[7:0];
						wtsnd_pkg::REG_CNT_HI: res_rd_q <= irq_cnt_q[15:8];
						wtsnd_pkg::REG_RAM:    res_rd_q <= '0;
						default:               res_rd_q <= open_bus;
					endcase
				end else begin
					res_rd_q <= '0;
				end
			end
			wtsnd_pkg::S_CRD: begin
				res_rd_q <= rdata;
			end
			wtsnd_pkg::S_LOAD: begin
				if (ld_cnt_q == 4'd1) begin
					ch_q <= ch_now;
				end else if (ld_cnt_q >= 4'd2) begin
					chreg_q[ld_wr] <= rdata;
				end
			end
			wtsnd_pkg::S_PREP: begin
				dx_q    <= sum25[24:16];
				lo16_q  <= sum25[15:0];
				rem_q   <= '0;
				phase_q <= p24;
			end
			wtsnd_pkg::S_DIV: begin
				rem_q <= rem_nx;
				dx_q  <= {dx_q[7:0], 1'b0};
				if (div_cnt_q == wtsnd_pkg::DIV_LAST) begin
					phase_q <= {rem_nx, lo16_q};
				end
			end
			wtsnd_pkg::S_NIB: begin
				nib_hi_q <= idx8[0];
			end
			wtsnd_pkg::S_NIBD: begin
				raw_q <= raw_full[7:0];
			end
			wtsnd_pkg::S_MUL1: begin
				prod_q <= prod_d;
			end
			wtsnd_pkg::S_MUL2: begin
				quo_q <= quo_full[27:wtsnd_pkg::RECIP_SHIFT];
				neg_q <= prod_q[15];
			end
			wtsnd_pkg::S_WB: begin
				res_sv_q  <= 1'b1;
				res_ch_q  <= ch_q;
				res_val_q <= sat_val;
			end
			wtsnd_pkg::S_DONE: begin
				if (out_free) begin
					read_data_q <= res_rd_q;
					irq_q       <= irq_pend_q;
					sv_q        <= res_sv_q;
					ch_out_q    <= res_ch_q;
					val_q       <= res_val_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign irq_line       = irq_q;
	assign sample_valid   = sv_q;
	assign sample_channel = ch_out_q;
	assign sample_value   = val_q;

endmodule
`default_nettype wire

[design/wtsnd_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module wtsnd_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [7:0]       read_data,
	input wire logic             sample_valid,
	input wire logic [2:0]       sample_channel,
	input wire logic signed [8:0] sample_value
);

	// one word in flight: an accepted word blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// no sample means zero channel and value
	a_idle_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_valid |-> (sample_value == 9'sd0) && (sample_channel == 3'd0))
		else $error("sample fields set without sample");

	// a word with nonzero read data never carries a sample
	a_read_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_data != 8'd0) |-> !sample_valid)
		else $error("read data and sample in one word");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_value))
		else $error("stalled result changed");

endmodule

bind wavetable_sound_ram_and_irq_unit wtsnd_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.read_data     (read_data),
	.sample_valid  (sample_valid),
	.sample_channel(sample_channel),
	.sample_value  (sample_value)
);
`default_nettype wire
